>>> src/spm_pkg.sv
// package: shared types and constants of the sparse polynomial multiplier
`timescale 1ns / 1ps
package spm_pkg;

    localparam int MaxTermsDefault = 8;
    localparam int ProdDepthDefault = 64;
    localparam int CoefWidth = 16;
    localparam int ExpoWidth = 8;
    localparam int SumCoefWidth = 41;
    localparam int SumExpoWidth = 9;

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MERGE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_a;      // store input term in first list
        logic load_b;      // store input term in second list
        logic start;       // clear product table and pair indexes
        logic mul;         // register current pair product
        logic merge_step;  // check one product table entry against the product
        logic merge_done;  // add product at merge target, advance pair
        logic scan_start;  // restart max search
        logic scan_step;   // check one table entry for max
        logic emit_load;   // move best entry into output register
        logic out_take;    // output word accepted
        logic clear;       // clear operand counts
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;       // either operand list empty
        logic merge_end;   // merge walk has reached the end or a match
        logic pairs_end;   // last pair handled
        logic scan_end;    // max search walked all entries
        logic found;       // max search found a live entry
        logic more;        // another live entry remains after this one
    } t_status;

endpackage

>>> src/spm_ctrl.sv
// controller: sequences load, multiply, merge, ordered emit
`timescale 1ns / 1ps
module spm_ctrl
    import spm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    output logic       o_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ready     = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.out_take = r_out_valid && i_out_ready;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_func)
                        FUNC_LOAD_A: o_cmd.load_a = 1'b1;
                        FUNC_LOAD_B: o_cmd.load_b = 1'b1;
                        FUNC_COMPUTE: begin
                            if (i_status.empty) begin
                                o_cmd.clear = 1'b1;
                            end else begin
                                o_cmd.start = 1'b1;
                                n_state = ST_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (i_status.merge_end) begin
                    o_cmd.merge_done = 1'b1;
                    if (i_status.pairs_end) begin
                        n_state = ST_SCAN_INIT;
                    end else begin
                        n_state = ST_MUL;
                    end
                end else begin
                    o_cmd.merge_step = 1'b1;
                end
            end
            // last table write has landed, start the first max search
            ST_SCAN_INIT: begin
                o_cmd.scan_start = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                // output register is free or frees this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit_load = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.more) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a found entry always precedes an emit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> i_status.found)
        else $error("emit without live entry");
    // output word holds while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("output word dropped");
    // no new input while working
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready during compute");

endmodule

>>> src/spm_dp.sv
// datapath: operand lists, product table in a generic ram, merge and max search
`timescale 1ns / 1ps
module spm_dp
    import spm_pkg::*;
#(
    parameter int MAX_TERMS = MaxTermsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [CoefWidth-1:0]    i_coef,
    input  logic [ExpoWidth-1:0]           i_expo,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    output logic signed [SumCoefWidth-1:0] o_sum_coefficient,
    output logic [SumExpoWidth-1:0]        o_sum_exponent,
    output logic                           o_last
);

    localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int PD = MAX_TERMS * MAX_TERMS;
    localparam int PW = (PD > 1) ? $clog2(PD) : 1;
    localparam int UW = $clog2(PD + 1);
    localparam int EW = SumCoefWidth + SumExpoWidth;

    logic signed [CoefWidth-1:0] r_a_coef [MAX_TERMS];
    logic [ExpoWidth-1:0]        r_a_expo [MAX_TERMS];
    logic signed [CoefWidth-1:0] r_b_coef [MAX_TERMS];
    logic [ExpoWidth-1:0]        r_b_expo [MAX_TERMS];
    logic [CW-1:0] r_a_cnt, r_b_cnt;
    logic [TW-1:0] r_i, r_j;

    // product table live bits and fill count
    logic [PD-1:0]                  r_alive;
    logic [UW-1:0]                  r_used;

    logic signed [2*CoefWidth-1:0]  r_prod;
    logic [SumExpoWidth-1:0]        r_pexp;
    logic [UW-1:0]                  r_k, n_k;
    logic [PW-1:0]                  r_best;
    logic signed [SumCoefWidth-1:0] r_best_coef;
    logic [SumExpoWidth-1:0]        r_best_expo;
    logic                           r_found;
    logic [UW-1:0]                  r_live;

    // product table ports, entry is {coefficient, exponent}
    logic                           tbl_we;
    logic [PW-1:0]                  tbl_waddr;
    logic [EW-1:0]                  tbl_wdata;
    logic [EW-1:0]                  tbl_rdata;
    logic signed [SumCoefWidth-1:0] rd_coef;
    logic [SumExpoWidth-1:0]        rd_expo;

    logic [PW-1:0] k_idx;
    logic          k_in, k_hit;
    logic          i_last, j_last;

    assign rd_coef = tbl_rdata[EW-1:SumExpoWidth];
    assign rd_expo = tbl_rdata[SumExpoWidth-1:0];

    assign k_idx  = r_k[PW-1:0];
    assign k_in   = (r_k < r_used);
    assign k_hit  = k_in && r_alive[k_idx] && (rd_expo == r_pexp);
    assign i_last = (CW'({1'b0, r_i}) == CW'(r_a_cnt - 1'b1));
    assign j_last = (CW'({1'b0, r_j}) == CW'(r_b_cnt - 1'b1));

    assign o_status.empty     = (r_a_cnt == '0) || (r_b_cnt == '0);
    assign o_status.merge_end = !k_in || k_hit;
    assign o_status.pairs_end = i_last && j_last;
    assign o_status.scan_end  = !k_in;
    assign o_status.found     = r_found;
    assign o_status.more      = (r_live > UW'(1));

    // operand lists and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else begin
            if (i_cmd.load_a && r_a_cnt < CW'(MAX_TERMS)) begin
                r_a_cnt <= r_a_cnt + 1'b1;
            end
            if (i_cmd.load_b && r_b_cnt < CW'(MAX_TERMS)) begin
                r_b_cnt <= r_b_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_a_cnt < CW'(MAX_TERMS)) begin
            r_a_coef[r_a_cnt[TW-1:0]] <= i_coef;
            r_a_expo[r_a_cnt[TW-1:0]] <= i_expo;
        end
        if (i_cmd.load_b && r_b_cnt < CW'(MAX_TERMS)) begin
            r_b_coef[r_b_cnt[TW-1:0]] <= i_coef;
            r_b_expo[r_b_cnt[TW-1:0]] <= i_expo;
        end
    end

    // walk pointer, the table is read at its next value so data matches r_k
    always_comb begin
        n_k = r_k;
        if (i_cmd.mul || i_cmd.scan_start) begin
            n_k = '0;
        end else if (i_cmd.merge_step || i_cmd.scan_step) begin
            n_k = r_k + 1'b1;
        end
    end

    // merge write: accumulate on a match, else append a new entry
    assign tbl_we    = i_cmd.merge_done;
    assign tbl_waddr = k_hit ? k_idx : r_used[PW-1:0];
    assign tbl_wdata = k_hit ? {rd_coef + SumCoefWidth'(r_prod), r_pexp}
                             : {SumCoefWidth'(r_prod), r_pexp};

    spm_ram #(.WIDTH(EW), .DEPTH(PD)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (n_k[PW-1:0]),
        .o_rdata (tbl_rdata)
    );

    // pair walk, live bits, fill count and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_used  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_found <= 1'b0;
            r_live  <= '0;
        end else begin
            r_k <= n_k;
            if (i_cmd.start) begin
                r_alive <= '0;
                r_used  <= '0;
                r_i     <= '0;
                r_j     <= '0;
            end
            if (i_cmd.merge_done) begin
                if (!k_hit) begin
                    r_alive[r_used[PW-1:0]] <= 1'b1;
                    r_used <= r_used + 1'b1;
                end
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_found <= 1'b0;
                r_live  <= '0;
            end
            if (i_cmd.scan_step && r_alive[k_idx]) begin
                r_live <= r_live + 1'b1;
                if (!r_found || rd_expo > r_best_expo) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.emit_load) begin
                r_alive[r_best] <= 1'b0;
            end
        end
    end

    // best entry so far in the max search
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_alive[k_idx]) begin
            if (!r_found || rd_expo > r_best_expo) begin
                r_best      <= k_idx;
                r_best_coef <= rd_coef;
                r_best_expo <= rd_expo;
            end
        end
    end

    // multiply one pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_a_coef[r_i] * r_b_coef[r_j];
            r_pexp <= SumExpoWidth'(r_a_expo[r_i]) + SumExpoWidth'(r_b_expo[r_j]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_sum_coefficient <= r_best_coef;
            o_sum_exponent    <= r_best_expo;
            o_last            <= !o_status.more;
        end
    end

    // table fill never passes the pair count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(PD))
        else $error("product table overflow");
    // a new entry always lands in a free slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.merge_done && !k_hit) |-> !r_alive[r_used[PW-1:0]])
        else $error("overwrite of live entry");

endmodule

// generic simple dual-port ram with registered read
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sparse_poly_multiply.sv
// top level: sparse polynomial multiplier
//
// channel  direction  handshake                   payload
// input    in         i_valid / o_ready           i_func, i_coef, i_expo
// result   out        o_valid / i_ready           o_sum_coefficient, o_sum_exponent, o_last
//
// a compute multiplies each term pair of the n1 and n2 terms and merges the product
// into the product table, then emits the r results by repeated max searches,
// with a table walk that checks one entry per cycle.
// synchronous active-low reset clears the counts and the product table valid bits.
// a stalled result holds the emit walk; input is refused until compute ends.
`timescale 1ns / 1ps
module sparse_poly_multiply
    import spm_pkg::*;
#(
    parameter int MAX_TERMS = MaxTermsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_func,
    input  logic signed [CoefWidth-1:0]    i_coef,
    input  logic [ExpoWidth-1:0]           i_expo,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SumCoefWidth-1:0] o_sum_coefficient,
    output logic [SumExpoWidth-1:0]        o_sum_exponent,
    output logic                           o_last
);

    t_cmd    cmd;
    t_status status;

    spm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    spm_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_coef            (i_coef),
        .i_expo            (i_expo),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_sum_coefficient (o_sum_coefficient),
        .o_sum_exponent    (o_sum_exponent),
        .o_last            (o_last)
    );

endmodule
